@@ src/tnos_pkg.sv @@
// Shared types and constants for the two-nearest obstacle search block.
// Holds the input, command and result item structs and the fixed field widths.
// No dependencies.
package tnos_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned CMDQ_DEPTH   = 2;
  localparam int unsigned RESQ_DEPTH   = 2;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned POS_W     = 20;
  localparam int unsigned DIST_W    = 13;
  localparam int unsigned RAD_W     = 2 * DIST_W;   // radicand of the root unit
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned DX_W      = POS_W + 1;    // scaled cell minus position
  localparam int unsigned SQ_W      = 2 * POS_W;    // one squared axis distance
  localparam int unsigned SUM_W     = SQ_W + 1;

  localparam logic [DIST_W-1:0] RADIUS_LIMIT = 13'd5056;
  localparam logic [DIST_W-1:0] RADIUS_RESET = 13'd80;

  localparam logic [REQ_W-1:0] REQ_ADD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QRY = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_CLR,
    OP_QRY,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [CELL_W-1:0] obs_x;
    logic signed [CELL_W-1:0] obs_y;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
  } in_item_t;

  typedef struct packed {
    op_t                      op;
    logic signed [CELL_W-1:0] x;
    logic signed [CELL_W-1:0] y;
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
  } cmd_t;

  typedef struct packed {
    logic                     status;
    logic [CNT_OUT_W-1:0]     observable_count;
    logic                     first_valid;
    logic signed [CELL_W-1:0] first_x;
    logic signed [CELL_W-1:0] first_y;
    logic [DIST_W-1:0]        first_dist;
    logic                     second_valid;
    logic signed [CELL_W-1:0] second_x;
    logic signed [CELL_W-1:0] second_y;
    logic [DIST_W-1:0]        second_dist;
  } out_item_t;

endpackage

@@ src/tnos_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters; no package dependency.
module tnos_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/tnos_fifo.sv @@
// Small synchronous FIFO used as the command queue and the result queue.
// Depth must be a power of two; no package dependency.
module tnos_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

@@ src/tnos_front.sv @@
// Front end: accepts input items, decodes the request type into a command
// and queues it for the back end. Uses tnos_pkg and tnos_fifo.
module tnos_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  tnos_pkg::in_item_t in_data,
  output logic               cmd_valid,
  output tnos_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);
  import tnos_pkg::*;

  localparam int unsigned CMD_W = $bits(cmd_t);

  cmd_t             cmd_in;
  logic [CMD_W-1:0] q_rdata;
  logic             q_empty;

  always_comb begin
    cmd_in.x  = in_data.obs_x;
    cmd_in.y  = in_data.obs_y;
    cmd_in.px = in_data.pos_x;
    cmd_in.py = in_data.pos_y;
    case (in_data.req_type)
      REQ_ADD: cmd_in.op = OP_ADD;
      REQ_CLR: cmd_in.op = OP_CLR;
      REQ_QRY: cmd_in.op = OP_QRY;
      default: cmd_in.op = OP_NOP;
    endcase
  end

  tnos_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd       = cmd_t'(q_rdata);
  assign cmd_valid = !q_empty;

endmodule

@@ src/tnos_isqrt.sv @@
// Iterative floor square root, one result bit per cycle.
// Takes a RAD_W-bit radicand and returns a DIST_W-bit root. Uses tnos_pkg.
module tnos_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tnos_pkg::RAD_W-1:0]     radicand,
  output logic                           done,
  output logic [tnos_pkg::DIST_W-1:0]    root
);
  import tnos_pkg::*;

  localparam int unsigned REM_W = DIST_W + 1;
  localparam int unsigned TRY_W = REM_W + 2;
  localparam int unsigned SW    = $clog2(DIST_W);

  logic              busy_r, done_r;
  logic [SW-1:0]     step_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIST_W-1:0] root_r;
  logic [TRY_W-1:0]  rem_t, trial, diff;
  logic              ge;

  always_comb begin
    rem_t = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    ge    = (rem_t >= trial);
    diff  = rem_t - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= SW'(DIST_W - 1);
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? diff[REM_W-1:0] : rem_t[REM_W-1:0];
      root_r <= {root_r[DIST_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

@@ src/tnos_back.sv @@
// Back end: owns the obstacle table, runs adds, clears and query scans,
// takes the two square roots and pushes results. Uses tnos_pkg, tnos_ram,
// tnos_isqrt.
module tnos_back #(
  parameter int unsigned CAPACITY = tnos_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tnos_pkg::DIST_W-1:0]   cfg_wdata,
  input  logic                          cmd_valid,
  input  tnos_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output tnos_pkg::out_item_t           res
);
  import tnos_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned ROW_W = 2 * CELL_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_RT1  = 5'b00100,
    S_RT2  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [RAD_W-1:0] lim_r;
  logic [DIST_W-1:0] rad_clip;

  logic signed [POS_W-1:0] px_r, py_r;
  logic [CW-1:0]           scan_idx_r, scan_idx_nxt;

  // scan pipeline
  logic                     v0_r, v1_r, v2_r, v3_r;
  logic signed [DX_W-1:0]   dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [CELL_W-1:0] s1x_r, s1y_r, s2x_r, s2y_r, s3x_r, s3y_r;
  logic signed [2*DX_W-1:0] prodx, prody;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [SUM_W-1:0]         sum;
  logic [RAD_W-1:0]         dsq_r;
  logic                     inr_r;

  // running best two
  logic                     have1_r, have1_nxt, have2_r, have2_nxt;
  logic [RAD_W-1:0]         d1_r, d1_nxt, d2_r, d2_nxt;
  logic signed [CELL_W-1:0] x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [CW-1:0]            obs_cnt_r, obs_cnt_nxt;
  logic [DIST_W-1:0]        dist1_r, dist1_nxt, dist2_r, dist2_nxt;

  logic                     issue, scan_done;
  logic                     ram_we;
  logic [ROW_W-1:0]         ram_rdata;
  logic                     sq_start, sq_done;
  logic [RAD_W-1:0]         sq_rad;
  logic [DIST_W-1:0]        sq_root;

  tnos_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({cmd.x, cmd.y}),
    .re    (issue),
    .raddr (scan_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  tnos_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // radius limit squared, formed once per register write
  assign rad_clip = (cfg_wdata > RADIUS_LIMIT) ? RADIUS_LIMIT : cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= RAD_W'(RADIUS_RESET) * RAD_W'(RADIUS_RESET);
    end else if (cfg_we) begin
      lim_r <= RAD_W'(rad_clip) * RAD_W'(rad_clip);
    end
  end

  assign issue     = (state_r == S_SCAN) && (scan_idx_r < cnt_r);
  assign scan_done = (state_r == S_SCAN) && !issue && !v0_r && !v1_r && !v2_r && !v3_r;

  // pipeline datapath
  always_comb begin
    dx_nxt = {ram_rdata[ROW_W-1], ram_rdata[ROW_W-1 -: CELL_W], 4'b0000}
             - {px_r[POS_W-1], px_r};
    dy_nxt = {ram_rdata[CELL_W-1], ram_rdata[CELL_W-1:0], 4'b0000}
             - {py_r[POS_W-1], py_r};
    prodx  = dx_r * dx_r;
    prody  = dy_r * dy_r;
    sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  always_ff @(posedge clk) begin
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    s1x_r <= ram_rdata[ROW_W-1 -: CELL_W];
    s1y_r <= ram_rdata[CELL_W-1:0];
    sqx_r <= prodx[SQ_W-1:0];
    sqy_r <= prody[SQ_W-1:0];
    s2x_r <= s1x_r;
    s2y_r <= s1y_r;
    dsq_r <= sum[RAD_W-1:0];
    inr_r <= (sum < SUM_W'(lim_r));
    s3x_r <= s2x_r;
    s3y_r <= s2y_r;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scan_idx_nxt = issue ? scan_idx_r + 1'b1 : scan_idx_r;
    have1_nxt    = have1_r;
    have2_nxt    = have2_r;
    d1_nxt       = d1_r;
    d2_nxt       = d2_r;
    x1_nxt       = x1_r;
    y1_nxt       = y1_r;
    x2_nxt       = x2_r;
    y2_nxt       = y2_r;
    obs_cnt_nxt  = obs_cnt_r;
    dist1_nxt    = dist1_r;
    dist2_nxt    = dist2_r;
    cmd_pop      = 1'b0;
    ram_we       = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    sq_start     = 1'b0;
    sq_rad       = d1_r;

    // fold one in-range entry into the best two; strict compares keep
    // the lower index on ties
    if (v3_r && inr_r) begin
      obs_cnt_nxt = obs_cnt_r + 1'b1;
      if (!have1_r || dsq_r < d1_r) begin
        if (have1_r) begin
          have2_nxt = 1'b1;
          d2_nxt    = d1_r;
          x2_nxt    = x1_r;
          y2_nxt    = y1_r;
        end
        have1_nxt = 1'b1;
        d1_nxt    = dsq_r;
        x1_nxt    = s3x_r;
        y1_nxt    = s3y_r;
      end else if (!have2_r || dsq_r < d2_r) begin
        have2_nxt = 1'b1;
        d2_nxt    = dsq_r;
        x2_nxt    = s3x_r;
        y2_nxt    = s3y_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_QRY) begin
            cmd_pop      = 1'b1;
            scan_idx_nxt = '0;
            have1_nxt    = 1'b0;
            have2_nxt    = 1'b0;
            obs_cnt_nxt  = '0;
            state_nxt    = S_SCAN;
          end else if (!res_full) begin
            cmd_pop  = 1'b1;
            res_push = 1'b1;
            case (cmd.op)
              OP_ADD: begin
                if (cnt_r < CW'(CAPACITY)) begin
                  ram_we  = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end else begin
                  res.status = 1'b1;
                end
              end
              OP_CLR: begin
                cnt_nxt = '0;
              end
              default: begin
                cnt_nxt = cnt_r;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (have1_r) begin
            sq_start  = 1'b1;
            sq_rad    = d1_r;
            state_nxt = S_RT1;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_RT1: begin
        if (sq_done) begin
          dist1_nxt = sq_root;
          if (have2_r) begin
            sq_start  = 1'b1;
            sq_rad    = d2_r;
            state_nxt = S_RT2;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_RT2: begin
        if (sq_done) begin
          dist2_nxt = sq_root;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!res_full) begin
          res_push             = 1'b1;
          res.observable_count = CNT_OUT_W'(obs_cnt_r);
          if (have1_r) begin
            res.first_valid = 1'b1;
            res.first_x     = x1_r;
            res.first_y     = y1_r;
            res.first_dist  = dist1_r;
          end
          if (have2_r) begin
            res.second_valid = 1'b1;
            res.second_x     = x2_r;
            res.second_y     = y2_r;
            res.second_dist  = dist2_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      have1_r <= 1'b0;
      have2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      v0_r    <= issue;
      v1_r    <= v0_r;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      have1_r <= have1_nxt;
      have2_r <= have2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == OP_QRY) begin
      px_r <= cmd.px;
      py_r <= cmd.py;
    end
    scan_idx_r <= scan_idx_nxt;
    d1_r       <= d1_nxt;
    d2_r       <= d2_nxt;
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    obs_cnt_r  <= obs_cnt_nxt;
    dist1_r    <= dist1_nxt;
    dist2_r    <= dist2_nxt;
  end

endmodule

@@ src/two_nearest_obstacle_search.sv @@
// Two-nearest obstacle search: keeps a table of up to CAPACITY obstacle cells
// and, on a query, counts the cells within the observation radius of a position
// given in 1/16 cell units and returns the nearest two with their floor
// square-root distances. Requests go into a two-entry command queue and results
// come out of a two-entry result queue, so both sides can stall independently.
// An add, a clear or an unused request code is popped from the command queue
// in the same cycle that its result is pushed. A query scans the table through
// its single read port, one entry per cycle, then runs up to two 13-step square
// roots on one shared unit. Queries are handled one at a time. The table is
// not cleared after reset; only entries below the fill count are ever read.
module two_nearest_obstacle_search #(
  parameter int unsigned CAPACITY = tnos_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  tnos_pkg::in_item_t          in_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output tnos_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [tnos_pkg::DIST_W-1:0] cfg_wdata
);
  import tnos_pkg::*;

  localparam int unsigned RES_W = $bits(out_item_t);

  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic             res_full, res_push;
  out_item_t        res;
  logic [RES_W-1:0] resq_rdata;

  tnos_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tnos_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  tnos_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (resq_rdata),
    .empty (out_empty)
  );

  assign out_data = out_item_t'(resq_rdata);

endmodule
